/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gqd_pkg.sv */
// Shared types and constants for the gray quantizer with dither
package gqd_pkg;

    localparam int PIX_W       = 8;
    localparam int RND_W       = 16;
    localparam int RND_Q_W     = 7;
    localparam int RND_F_W     = RND_W - RND_Q_W;
    localparam int LEVELS_W    = 9;
    localparam int WIDTH_W     = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;
    localparam int DIV_STEPS   = 8;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_MAX_WIDTH = 4096;

    localparam logic [LEVELS_W-1:0] LEVELS_MAX   = 9'd256;
    localparam logic [LEVELS_W-1:0] RST_LEVELS   = 9'd16;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH    = 13'd640;
    localparam logic [PIX_W-1:0]    HALF_STEP    = 8'h80;
    localparam logic [PIX_W-1:0]    PIX_MAX      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_LEVELS = 2'd0,
        REG_DITHER_EN  = 2'd1,
        REG_IMG_WIDTH  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_JDIV,
        S_SUM,
        S_MUL,
        S_QDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [RND_Q_W-1:0] rnd_q;
        logic               frac_nz;
        logic               dither;
        logic               positive;
    } t_item;

endpackage

/* rtl/gqd_front.sv */
// Front end: input acceptance, checkerboard sign and row/column tracking
module gqd_front #(
    parameter int MAX_WIDTH = gqd_pkg::DEF_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gqd_pkg::PIX_W-1:0]   i_pix,
    input  logic [gqd_pkg::RND_W-1:0]   i_rnd,
    input  logic                        i_start,
    input  logic                        i_dither_en,
    input  logic [gqd_pkg::WIDTH_W-1:0] i_image_width,
    input  logic                        i_full,
    output logic                        o_push,
    output gqd_pkg::t_item              o_item
);
    import gqd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;

    logic [CW-1:0] r_col, n_col, col0;
    logic          r_par, n_par, par0;
    logic [XW-1:0] last_col;
    logic          at_end;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        col0 = i_start ? '0 : r_col;
        par0 = i_start ? 1'b0 : r_par;
        if (i_image_width == '0) begin
            last_col = '0;
        end else if (XW'(i_image_width) > XW'(MAX_WIDTH)) begin
            last_col = XW'(MAX_WIDTH - 1);
        end else begin
            last_col = XW'(i_image_width) - XW'(1);
        end
        at_end = XW'(col0) >= last_col;
        n_col  = r_col;
        n_par  = r_par;
        if (o_push) begin
            if (i_dither_en) begin
                if (at_end) begin
                    n_col = '0;
                    n_par = ~par0;
                end else begin
                    n_col = col0 + CW'(1);
                    n_par = par0;
                end
            end else begin
                n_col = col0;
                n_par = par0;
            end
        end
    end

    always_comb begin
        o_item.pix      = i_pix;
        o_item.rnd_q    = i_rnd[RND_W-1:RND_F_W];
        o_item.frac_nz  = |i_rnd[RND_F_W-1:0];
        o_item.dither   = i_dither_en;
        o_item.positive = (par0 == col0[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_par <= 1'b0;
        end else begin
            r_col <= n_col;
            r_par <= n_par;
        end
    end

endmodule

/* rtl/gqd_queue.sv */
// Short item queue between front end and back end
module gqd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gqd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output gqd_pkg::t_item o_item
);
    import gqd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/gqd_back.sv */
// Back end: jitter, clipping and level quantization on a shared serial divider
module gqd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  gqd_pkg::t_item               i_item,
    output logic                         o_pop,
    input  logic [gqd_pkg::LEVELS_W-1:0] i_levels,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gqd_pkg::PIX_W-1:0]    o_data
);
    import gqd_pkg::*;

    t_state                r_state, n_state;
    logic [PIX_W-1:0]      r_pix, n_pix;
    logic                  r_pos, n_pos;
    logic                  r_fnz, n_fnz;
    logic [PIX_W-1:0]      r_k, n_k;
    logic [PIX_W-1:0]      r_rem, n_rem;
    logic [PIX_W-1:0]      r_dvd, n_dvd;
    logic [PIX_W-1:0]      r_quo, n_quo;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  r_ovalid, n_ovalid;
    logic [PIX_W-1:0]      r_odata, n_odata;

    logic [PIX_W:0]        shifted;
    logic [PIX_W+1:0]      diff;
    logic                  ge;
    logic [PIX_W-1:0]      rem_step;
    logic [PIX_W:0]        sum9;
    logic [PIX_W:0]        sub9;
    logic [PIX_W-1:0]      k_sum;
    logic [2*PIX_W:0]      prod;
    logic                  out_free;

    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        shifted  = {r_rem, r_dvd[PIX_W-1]};
        diff     = {1'b0, shifted} - {1'b0, i_levels};
        ge       = !diff[PIX_W+1];
        rem_step = ge ? diff[PIX_W-1:0] : shifted[PIX_W-1:0];

        if (r_pos) begin
            sum9  = {1'b0, r_pix} + {1'b0, r_quo};
            sub9  = '0;
            k_sum = sum9[PIX_W] ? PIX_MAX : sum9[PIX_W-1:0];
        end else begin
            sum9  = '0;
            sub9  = {1'b0, r_quo} + (PIX_W+1)'(r_fnz || (r_rem != '0));
            k_sum = ({1'b0, r_pix} < sub9) ? '0 : r_pix - sub9[PIX_W-1:0];
        end

        prod = (2*PIX_W+1)'(r_k) * (2*PIX_W+1)'(i_levels);
    end

    always_comb begin
        n_state  = r_state;
        n_pix    = r_pix;
        n_pos    = r_pos;
        n_fnz    = r_fnz;
        n_k      = r_k;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_ready;
        o_pop    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_pix = i_item.pix;
                    n_pos = i_item.positive;
                    n_fnz = i_item.frac_nz;
                    if (i_item.dither) begin
                        n_rem   = '0;
                        n_dvd   = {1'b0, i_item.rnd_q};
                        n_quo   = '0;
                        n_cnt   = '0;
                        n_state = S_JDIV;
                    end else begin
                        n_k     = i_item.pix;
                        n_state = S_MUL;
                    end
                end
            end
            S_JDIV, S_QDIV: begin
                n_rem = rem_step;
                n_dvd = {r_dvd[PIX_W-2:0], 1'b0};
                n_quo = {r_quo[PIX_W-2:0], ge};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = (r_state == S_JDIV) ? S_SUM : S_OUT;
                end
            end
            S_SUM: begin
                n_k     = k_sum;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_rem   = prod[2*PIX_W-1:PIX_W];
                n_dvd   = HALF_STEP;
                n_quo   = '0;
                n_cnt   = '0;
                n_state = S_QDIV;
            end
            S_OUT: begin
                if (out_free) begin
                    n_odata  = r_quo;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pix   <= n_pix;
        r_pos   <= n_pos;
        r_fnz   <= n_fnz;
        r_k     <= n_k;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* rtl/gray_quantizer_with_dither_core.sv */
// Top level of the gray quantizer with dither: config registers and block wiring
//
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+------------------------------
// s_axis    | in        | tvalid / tready             | tdata: pixel_in, random_fraction
//           |           |                             | tuser: channel_start
// m_axis    | out       | tvalid / tready             | tdata: pixel_out
// cfg       | in        | valid / ready (always 1)    | index, data
//
// With dither on a pixel passes twice through the shared restoring divider, with
// dither off once; the divider retires one quotient bit per cycle.
// Synchronous active-low reset clears state, column/parity tracking, queue and output valid.
// The input side takes transactions while the two-entry queue has room; a stalled
// output holds its pixel and blocks only the back end.
module gray_quantizer_with_dither_core #(
    parameter int MAX_WIDTH = gqd_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] pixel_in, [23:8] random_fraction
    input  logic [gqd_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] channel_start
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] pixel_out
    output logic [gqd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gqd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gqd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gqd_pkg::*;

    logic [LEVELS_W-1:0] r_num_levels, n_num_levels;
    logic                r_dither_en, n_dither_en;
    logic [WIDTH_W-1:0]  r_image_width, n_image_width;
    logic [LEVELS_W-1:0] eff_levels;

    t_item q_in, q_out;
    logic  q_push, q_full, q_pop, q_valid;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_num_levels  = r_num_levels;
        n_dither_en   = r_dither_en;
        n_image_width = r_image_width;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_NUM_LEVELS: n_num_levels  = i_cfg_data[LEVELS_W-1:0];
                REG_DITHER_EN:  n_dither_en   = i_cfg_data[0];
                REG_IMG_WIDTH:  n_image_width = i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
        if (r_num_levels == '0) begin
            eff_levels = LEVELS_W'(1);
        end else if (r_num_levels > LEVELS_MAX) begin
            eff_levels = LEVELS_MAX;
        end else begin
            eff_levels = r_num_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels  <= RST_LEVELS;
            r_dither_en   <= 1'b0;
            r_image_width <= RST_WIDTH;
        end else begin
            r_num_levels  <= n_num_levels;
            r_dither_en   <= n_dither_en;
            r_image_width <= n_image_width;
        end
    end

    gqd_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_pix         (i_s_axis_tdata[PIX_W-1:0]),
        .i_rnd         (i_s_axis_tdata[PIX_W+RND_W-1:PIX_W]),
        .i_start       (i_s_axis_tuser),
        .i_dither_en   (r_dither_en),
        .i_image_width (r_image_width),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    gqd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    gqd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_out),
        .o_pop    (q_pop),
        .i_levels (eff_levels),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

/* rtl/gqd_checker.sv */
// Port-level assertion checker for the gray quantizer core, with its bind
`include "assert_macros.svh"

module gqd_port_assert (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [gqd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import gqd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH + 3);

    logic [PW-1:0] r_pend, n_pend;
    logic          in_acc, out_acc;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_pend = r_pend + PW'(in_acc) - PW'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "stalled output pixel changed")
    `ASSERT_IMPL(a_out_has_src, i_clk, i_rst_n,
        o_m_axis_tvalid, r_pend != '0,
        "output pixel without pending input")
    `ASSERT_IMPL(a_pend_bound, i_clk, i_rst_n,
        1'b1, r_pend <= PW'(QUEUE_DEPTH + 2),
        "more pixels in flight than storage")
    `ASSERT_IMPL(a_stall_full, i_clk, i_rst_n,
        !o_s_axis_tready, r_pend >= PW'(QUEUE_DEPTH),
        "input stalled with queue not full")

endmodule

bind gray_quantizer_with_dither_core gqd_port_assert u_gqd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
